// File: hw/rtl/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    localparam int SqrtSteps = 66;
    localparam int DivSteps  = 32;
    localparam logic [30:0] RadiusReset = 31'd65536;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_low;
        logic signed [31:0] t_high;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_hit;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic               back_face;
    } res_t;

    typedef struct packed {
        ray_t        ray;
        logic [65:0] h;
        logic [63:0] a;
        logic        miss;
    } sq_side_t;

    typedef struct packed {
        logic [131:0] rad;
        logic [67:0]  rem;
        logic [65:0]  root;
        sq_side_t     side;
    } sq_cell_t;

    typedef struct packed {
        ray_t ray;
        logic miss;
        logic neg1;
        logic neg2;
        logic ovf1;
        logic ovf2;
    } dv_side_t;

    typedef struct packed {
        logic [31:0] num1;
        logic [31:0] num2;
        logic [63:0] rem1;
        logic [63:0] rem2;
        logic [31:0] q1;
        logic [31:0] q2;
        logic [63:0] dvsr;
        dv_side_t    side;
    } dv_cell_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsi_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vin,
    input  wire rsi_pkg::sq_cell_t din,
    output logic                  vout,
    output rsi_pkg::sq_cell_t     dout
);

    logic              vld_reg;
    rsi_pkg::sq_cell_t dat_reg;
    rsi_pkg::sq_cell_t dat_next;
    logic [67:0]       rem_sh;
    logic [67:0]       trial;
    logic              ge;

    // One root bit per cell: bring down the next two radicand bits and try 4*root+1.
    always_comb
    begin
        rem_sh        = {din.rem[65:0], din.rad[131:130]};
        trial         = {din.root, 2'b01};
        ge            = (rem_sh >= trial);
        dat_next      = din;
        dat_next.rad  = {din.rad[129:0], 2'b00};
        dat_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        dat_next.root = {din.root[64:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg <= dat_next;
        end
    end

    assign vout = vld_reg;
    assign dout = dat_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rsi_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vin,
    input  wire rsi_pkg::dv_cell_t din,
    output logic                  vout,
    output rsi_pkg::dv_cell_t     dout
);

    logic              vld_reg;
    rsi_pkg::dv_cell_t dat_reg;
    rsi_pkg::dv_cell_t dat_next;
    logic [64:0]       r1;
    logic [64:0]       r2;
    logic              ge1;
    logic              ge2;

    // Restoring division, one quotient bit per cell for both roots.
    always_comb
    begin
        r1            = {din.rem1, din.num1[31]};
        r2            = {din.rem2, din.num2[31]};
        ge1           = (r1 >= {1'b0, din.dvsr});
        ge2           = (r2 >= {1'b0, din.dvsr});
        dat_next      = din;
        dat_next.num1 = {din.num1[30:0], 1'b0};
        dat_next.num2 = {din.num2[30:0], 1'b0};
        dat_next.rem1 = ge1 ? 64'(r1 - {1'b0, din.dvsr}) : r1[63:0];
        dat_next.rem2 = ge2 ? 64'(r2 - {1'b0, din.dvsr}) : r2[63:0];
        dat_next.q1   = {din.q1[30:0], ge1};
        dat_next.q2   = {din.q2[30:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg <= dat_next;
        end
    end

    assign vout = vld_reg;
    assign dout = dat_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ray_sphere_intersect.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake               Payload
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (register write)
// ray      ray_valid / ray_ready   ray (origin, direction, t interval)
// res      res_valid / res_ready   res (hit, t, position, normal, back face)
//
// One ray is accepted per cycle while the output skid register is empty.
// The pipeline is made of the square-root chain (66 cells, one root bit each),
// the divider chain (32 cells, one quotient bit each), 18 arithmetic stages
// and the output register.
// Reset clears all valid flags and loads the register reset values.
// The whole pipeline advances together and holds only while the output skid
// register is occupied, so a waiting result does not block the next ray.

module ray_sphere_intersect (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          ray_valid,
    output logic               ray_ready,
    input  wire rsi_pkg::ray_t ray,
    output logic               res_valid,
    input  wire logic          res_ready,
    output rsi_pkg::res_t      res
);

    function automatic logic [31:0] org_of(input rsi_pkg::ray_t r, input int i);
        logic [31:0] v;
        case (i)
            0:       v = r.origin_x;
            1:       v = r.origin_y;
            default: v = r.origin_z;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] dir_of(input rsi_pkg::ray_t r, input int i);
        logic [31:0] v;
        case (i)
            0:       v = r.dir_x;
            1:       v = r.dir_y;
            default: v = r.dir_z;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [2:0][31:0] cen_reg;
    logic [30:0]      radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg    <= '0;
            radius_reg <= rsi_pkg::RadiusReset;
        end
        else if (cfg_valid)
        begin
            unique case (rsi_pkg::cfg_idx_t'(cfg_index))
                rsi_pkg::CFG_CENTER_X: cen_reg[0] <= cfg_data;
                rsi_pkg::CFG_CENTER_Y: cen_reg[1] <= cfg_data;
                rsi_pkg::CFG_CENTER_Z: cen_reg[2] <= cfg_data;
                rsi_pkg::CFG_RADIUS:   radius_reg <= cfg_data[30:0];
                default:               radius_reg <= radius_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Pipeline control.
    logic          adv;
    logic [18:1]   vld_reg;
    logic          out_vld_reg;
    logic          skid_vld_reg;
    rsi_pkg::res_t out_dat_reg;
    rsi_pkg::res_t skid_dat_reg;

    assign adv       = !skid_vld_reg;
    assign ray_ready = adv;

    // Stage registers.
    rsi_pkg::ray_t    s1_ray_reg;
    logic [2:0][32:0] s1_so_reg;
    rsi_pkg::ray_t    s2_ray_reg;
    logic [2:0][63:0] s2_dd_reg;
    logic [2:0][64:0] s2_sd_reg;
    logic [2:0][64:0] s2_ss_reg;
    logic [61:0]      s2_rr_reg;
    rsi_pkg::ray_t    s3_ray_reg;
    logic [63:0]      s3_a_reg;
    logic [65:0]      s3_h_reg;
    logic [66:0]      s3_k_reg;
    rsi_pkg::ray_t    s4_ray_reg;
    logic [63:0]      s4_a_reg;
    logic [65:0]      s4_h_reg;
    logic [64:0]      s4_habs_reg;
    logic [65:0]      s4_kabs_reg;
    logic             s4_kneg_reg;
    logic             s4_amiss_reg;
    rsi_pkg::ray_t    s5_ray_reg;
    logic [63:0]      s5_a_reg;
    logic [65:0]      s5_h_reg;
    logic             s5_kneg_reg;
    logic             s5_amiss_reg;
    logic [63:0]      s5_hll_reg;
    logic [64:0]      s5_hlh_reg;
    logic [65:0]      s5_hhh_reg;
    logic [63:0]      s5_akll_reg;
    logic [65:0]      s5_aklh_reg;
    logic [63:0]      s5_akhl_reg;
    logic [65:0]      s5_akhh_reg;
    rsi_pkg::ray_t    s6_ray_reg;
    logic [63:0]      s6_a_reg;
    logic [65:0]      s6_h_reg;
    logic             s6_kneg_reg;
    logic             s6_amiss_reg;
    logic [129:0]     s6_h2_reg;
    logic [129:0]     s6_ak_reg;
    rsi_pkg::sq_cell_t s7_cell_reg;
    rsi_pkg::sq_cell_t s7_cell_next;
    rsi_pkg::sq_side_t s8_side_reg;
    logic [67:0]      s8_tlo_reg;
    logic [67:0]      s8_thi_reg;
    rsi_pkg::sq_side_t s9_side_reg;
    logic [66:0]      s9_mag1_reg;
    logic [66:0]      s9_mag2_reg;
    logic             s9_neg1_reg;
    logic             s9_neg2_reg;
    rsi_pkg::dv_cell_t s10_cell_reg;
    rsi_pkg::dv_cell_t s10_cell_next;
    rsi_pkg::dv_side_t s11_side_reg;
    logic [33:0]      s11_q1_reg;
    logic [33:0]      s11_q2_reg;
    rsi_pkg::ray_t    s12_ray_reg;
    logic             s12_hit_reg;
    logic [31:0]      s12_tv_reg;
    rsi_pkg::ray_t    s13_ray_reg;
    logic             s13_hit_reg;
    logic [31:0]      s13_tv_reg;
    logic [2:0][63:0] s13_prod_reg;
    rsi_pkg::ray_t    s14_ray_reg;
    logic             s14_hit_reg;
    logic [31:0]      s14_tv_reg;
    logic [2:0][48:0] s14_p_reg;
    rsi_pkg::ray_t    s15_ray_reg;
    logic             s15_hit_reg;
    logic [31:0]      s15_tv_reg;
    logic [2:0][48:0] s15_p_reg;
    logic [2:0][49:0] s15_nv_reg;
    logic             s16_hit_reg;
    logic [31:0]      s16_tv_reg;
    logic [2:0][48:0] s16_p_reg;
    logic [2:0][49:0] s16_nv_reg;
    logic [2:0][64:0] s16_dl_reg;
    logic [2:0][49:0] s16_dh_reg;
    logic             s17_hit_reg;
    logic [31:0]      s17_tv_reg;
    logic [2:0][48:0] s17_p_reg;
    logic [2:0][49:0] s17_nv_reg;
    logic [2:0][81:0] s17_e_reg;
    rsi_pkg::res_t    s18_res_reg;
    rsi_pkg::res_t    s18_res_next;

    // Cell chains.
    logic              sq_vld [0:rsi_pkg::SqrtSteps];
    rsi_pkg::sq_cell_t sq_dat [0:rsi_pkg::SqrtSteps];
    logic              dv_vld [0:rsi_pkg::DivSteps];
    rsi_pkg::dv_cell_t dv_dat [0:rsi_pkg::DivSteps];

    assign sq_vld[0] = vld_reg[7];
    assign sq_dat[0] = s7_cell_reg;
    assign dv_vld[0] = vld_reg[10];
    assign dv_dat[0] = s10_cell_reg;

    for (genvar k = 0; k < rsi_pkg::SqrtSteps; k++)
    begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .vin  (sq_vld[k]),
            .din  (sq_dat[k]),
            .vout (sq_vld[k+1]),
            .dout (sq_dat[k+1])
        );
    end

    for (genvar k = 0; k < rsi_pkg::DivSteps; k++)
    begin : g_div
        rsi_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .vin  (dv_vld[k]),
            .din  (dv_dat[k]),
            .vout (dv_vld[k+1]),
            .dout (dv_dat[k+1])
        );
    end

    // Stage 7 and stage 10 feed the chains.
    always_comb
    begin
        logic [131:0] d;
        d = s6_kneg_reg ? (132'(s6_h2_reg) + 132'(s6_ak_reg))
                        : (132'(s6_h2_reg) - 132'(s6_ak_reg));
        s7_cell_next           = '0;
        s7_cell_next.rad       = d;
        s7_cell_next.side.ray  = s6_ray_reg;
        s7_cell_next.side.h    = s6_h_reg;
        s7_cell_next.side.a    = s6_a_reg;
        s7_cell_next.side.miss = s6_amiss_reg | d[131];
    end

    always_comb
    begin
        s10_cell_next           = '0;
        s10_cell_next.num1      = {s9_mag1_reg[15:0], 16'd0};
        s10_cell_next.num2      = {s9_mag2_reg[15:0], 16'd0};
        s10_cell_next.rem1      = 64'(s9_mag1_reg[66:16]);
        s10_cell_next.rem2      = 64'(s9_mag2_reg[66:16]);
        s10_cell_next.dvsr      = s9_side_reg.a;
        s10_cell_next.side.ray  = s9_side_reg.ray;
        s10_cell_next.side.miss = s9_side_reg.miss;
        s10_cell_next.side.neg1 = s9_neg1_reg;
        s10_cell_next.side.neg2 = s9_neg2_reg;
        // A quotient of 2^32 or more lies outside any 32-bit interval.
        s10_cell_next.side.ovf1 = 64'(s9_mag1_reg[66:16]) >= s9_side_reg.a;
        s10_cell_next.side.ovf2 = 64'(s9_mag2_reg[66:16]) >= s9_side_reg.a;
    end

    // Final stage: sign of d . n and saturation.
    always_comb
    begin
        logic [83:0] dot;
        dot = 84'($signed(s17_e_reg[0])) + 84'($signed(s17_e_reg[1]))
            + 84'($signed(s17_e_reg[2]));
        s18_res_next = '0;
        if (s17_hit_reg)
        begin
            s18_res_next.hit       = 1'b1;
            s18_res_next.t_hit     = s17_tv_reg;
            s18_res_next.pos_x     = sat32(50'($signed(s17_p_reg[0])));
            s18_res_next.pos_y     = sat32(50'($signed(s17_p_reg[1])));
            s18_res_next.pos_z     = sat32(50'($signed(s17_p_reg[2])));
            s18_res_next.norm_x    = sat32($signed(s17_nv_reg[0]));
            s18_res_next.norm_y    = sat32($signed(s17_nv_reg[1]));
            s18_res_next.norm_z    = sat32($signed(s17_nv_reg[2]));
            s18_res_next.back_face = !dot[83] && (dot != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[17:11], dv_vld[rsi_pkg::DivSteps], vld_reg[9:8],
                        sq_vld[rsi_pkg::SqrtSteps], vld_reg[6:1], ray_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Offset from the center and the dot products.
            s1_ray_reg <= ray;
            for (int i = 0; i < 3; i++)
            begin
                s1_so_reg[i] <= 33'($signed(org_of(ray, i))) - 33'($signed(cen_reg[i]));
            end

            s2_ray_reg <= s1_ray_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_dd_reg[i] <= 64'($signed(dir_of(s1_ray_reg, i))
                                    * $signed(dir_of(s1_ray_reg, i)));
                s2_sd_reg[i] <= 65'($signed(s1_so_reg[i]) * $signed(dir_of(s1_ray_reg, i)));
                s2_ss_reg[i] <= 65'($signed(s1_so_reg[i]) * $signed(s1_so_reg[i]));
            end
            s2_rr_reg <= 62'(radius_reg * radius_reg);

            s3_ray_reg <= s2_ray_reg;
            s3_a_reg   <= s2_dd_reg[0] + s2_dd_reg[1] + s2_dd_reg[2];
            s3_h_reg   <= 66'($signed(s2_sd_reg[0])) + 66'($signed(s2_sd_reg[1]))
                        + 66'($signed(s2_sd_reg[2]));
            s3_k_reg   <= 67'(s2_ss_reg[0]) + 67'(s2_ss_reg[1]) + 67'(s2_ss_reg[2])
                        - 67'(s2_rr_reg);

            // Magnitudes for the discriminant products.
            s4_ray_reg   <= s3_ray_reg;
            s4_a_reg     <= s3_a_reg;
            s4_h_reg     <= s3_h_reg;
            s4_habs_reg  <= s3_h_reg[65] ? 65'(-s3_h_reg) : s3_h_reg[64:0];
            s4_kabs_reg  <= s3_k_reg[66] ? 66'(-s3_k_reg) : s3_k_reg[65:0];
            s4_kneg_reg  <= s3_k_reg[66];
            s4_amiss_reg <= (s3_a_reg == '0);

            s5_ray_reg   <= s4_ray_reg;
            s5_a_reg     <= s4_a_reg;
            s5_h_reg     <= s4_h_reg;
            s5_kneg_reg  <= s4_kneg_reg;
            s5_amiss_reg <= s4_amiss_reg;
            s5_hll_reg   <= 64'(s4_habs_reg[31:0] * s4_habs_reg[31:0]);
            s5_hlh_reg   <= 65'(s4_habs_reg[31:0] * s4_habs_reg[64:32]);
            s5_hhh_reg   <= 66'(s4_habs_reg[64:32] * s4_habs_reg[64:32]);
            s5_akll_reg  <= 64'(s4_a_reg[31:0] * s4_kabs_reg[31:0]);
            s5_aklh_reg  <= 66'(s4_a_reg[31:0] * s4_kabs_reg[65:32]);
            s5_akhl_reg  <= 64'(s4_a_reg[63:32] * s4_kabs_reg[31:0]);
            s5_akhh_reg  <= 66'(s4_a_reg[63:32] * s4_kabs_reg[65:32]);

            s6_ray_reg   <= s5_ray_reg;
            s6_a_reg     <= s5_a_reg;
            s6_h_reg     <= s5_h_reg;
            s6_kneg_reg  <= s5_kneg_reg;
            s6_amiss_reg <= s5_amiss_reg;
            s6_h2_reg    <= 130'({s5_hhh_reg, 64'd0}) + 130'({s5_hlh_reg, 33'd0})
                          + 130'(s5_hll_reg);
            s6_ak_reg    <= 130'({s5_akhh_reg, 64'd0}) + 130'({s5_aklh_reg, 32'd0})
                          + 130'({s5_akhl_reg, 32'd0}) + 130'(s5_akll_reg);

            s7_cell_reg <= s7_cell_next;

            // Numerators -H -/+ sqrt(D).
            s8_side_reg <= sq_dat[rsi_pkg::SqrtSteps].side;
            s8_tlo_reg  <= 68'(-$signed(sq_dat[rsi_pkg::SqrtSteps].side.h))
                         - 68'(sq_dat[rsi_pkg::SqrtSteps].root);
            s8_thi_reg  <= 68'(-$signed(sq_dat[rsi_pkg::SqrtSteps].side.h))
                         + 68'(sq_dat[rsi_pkg::SqrtSteps].root);

            s9_side_reg <= s8_side_reg;
            s9_neg1_reg <= s8_tlo_reg[67];
            s9_neg2_reg <= s8_thi_reg[67];
            s9_mag1_reg <= s8_tlo_reg[67] ? 67'(-s8_tlo_reg) : s8_tlo_reg[66:0];
            s9_mag2_reg <= s8_thi_reg[67] ? 67'(-s8_thi_reg) : s8_thi_reg[66:0];

            s10_cell_reg <= s10_cell_next;

            // Floor division: a negative numerator rounds its magnitude up.
            s11_side_reg <= dv_dat[rsi_pkg::DivSteps].side;
            s11_q1_reg   <= dv_dat[rsi_pkg::DivSteps].side.neg1
                          ? 34'(-(34'(dv_dat[rsi_pkg::DivSteps].q1)
                                  + 34'(dv_dat[rsi_pkg::DivSteps].rem1 != '0)))
                          : 34'(dv_dat[rsi_pkg::DivSteps].q1);
            s11_q2_reg   <= dv_dat[rsi_pkg::DivSteps].side.neg2
                          ? 34'(-(34'(dv_dat[rsi_pkg::DivSteps].q2)
                                  + 34'(dv_dat[rsi_pkg::DivSteps].rem2 != '0)))
                          : 34'(dv_dat[rsi_pkg::DivSteps].q2);

            s12_ray_reg <= s11_side_reg.ray;
            begin
                logic in1;
                logic in2;
                in1 = !s11_side_reg.ovf1
                    && ($signed(s11_q1_reg) >= 34'($signed(s11_side_reg.ray.t_low)))
                    && ($signed(s11_q1_reg) <= 34'($signed(s11_side_reg.ray.t_high)));
                in2 = !s11_side_reg.ovf2
                    && ($signed(s11_q2_reg) >= 34'($signed(s11_side_reg.ray.t_low)))
                    && ($signed(s11_q2_reg) <= 34'($signed(s11_side_reg.ray.t_high)));
                s12_hit_reg <= !s11_side_reg.miss && (in1 || in2);
                s12_tv_reg  <= in1 ? s11_q1_reg[31:0] : s11_q2_reg[31:0];
            end

            // Hit position and normal.
            s13_ray_reg <= s12_ray_reg;
            s13_hit_reg <= s12_hit_reg;
            s13_tv_reg  <= s12_tv_reg;
            for (int i = 0; i < 3; i++)
            begin
                s13_prod_reg[i] <= 64'($signed(s12_tv_reg) * $signed(dir_of(s12_ray_reg, i)));
            end

            s14_ray_reg <= s13_ray_reg;
            s14_hit_reg <= s13_hit_reg;
            s14_tv_reg  <= s13_tv_reg;
            for (int i = 0; i < 3; i++)
            begin
                s14_p_reg[i] <= 49'($signed(org_of(s13_ray_reg, i)))
                              + 49'($signed(s13_prod_reg[i][63:16]));
            end

            s15_ray_reg <= s14_ray_reg;
            s15_hit_reg <= s14_hit_reg;
            s15_tv_reg  <= s14_tv_reg;
            s15_p_reg   <= s14_p_reg;
            for (int i = 0; i < 3; i++)
            begin
                s15_nv_reg[i] <= 50'($signed(s14_p_reg[i])) - 50'($signed(cen_reg[i]));
            end

            s16_hit_reg <= s15_hit_reg;
            s16_tv_reg  <= s15_tv_reg;
            s16_p_reg   <= s15_p_reg;
            s16_nv_reg  <= s15_nv_reg;
            for (int i = 0; i < 3; i++)
            begin
                s16_dl_reg[i] <= 65'($signed(dir_of(s15_ray_reg, i))
                                     * $signed({1'b0, s15_nv_reg[i][31:0]}));
                s16_dh_reg[i] <= 50'($signed(dir_of(s15_ray_reg, i))
                                     * $signed(s15_nv_reg[i][49:32]));
            end

            s17_hit_reg <= s16_hit_reg;
            s17_tv_reg  <= s16_tv_reg;
            s17_p_reg   <= s16_p_reg;
            s17_nv_reg  <= s16_nv_reg;
            for (int i = 0; i < 3; i++)
            begin
                s17_e_reg[i] <= 82'($signed({s16_dh_reg[i], 32'd0}))
                              + 82'($signed(s16_dl_reg[i]));
            end

            s18_res_reg <= s18_res_next;
        end
    end

    // Output register with a skid register behind it.
    logic push;
    logic pop;

    assign push = adv && vld_reg[18];
    assign pop  = out_vld_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                out_dat_reg <= skid_dat_reg;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                skid_dat_reg <= s18_res_reg;
            end
            else
            begin
                out_dat_reg <= s18_res_reg;
            end
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_dat_reg;

endmodule

`default_nettype wire
